>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> src/iccp_pkg.sv
package iccp_pkg;

	localparam int unsigned FIELD_BITS     = 16;
	localparam int unsigned CHANNEL_BITS   = 8;
	localparam int unsigned CFG_INDEX_BITS = 4;

	localparam logic [FIELD_BITS-1:0] LIMIT_RESET = 16'd100;
	localparam logic [FIELD_BITS-1:0] SHIFT_RESET = 16'd0;

	// 9 * 255, 15 * 255 and 255 * 255
	localparam int unsigned RED_GAIN   = 2295;
	localparam int unsigned GREEN_GAIN = 3825;
	localparam int unsigned BLUE_SCALE = 65025;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_ITERATION_LIMIT = 4'd0,
		CFG_PALETTE_SHIFT   = 4'd1
	} cfg_index_t;

	typedef struct packed {
		logic valid;
		logic black;
	} pipe_ctl_t;

endpackage

>>> src/iccp_delay.sv
module iccp_delay #(
	parameter int unsigned W = 2,
	parameter int unsigned N = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				line_s[i] <= '0;
			end
		end else if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign q = line_s[N-1];

endmodule

>>> src/iccp_div.sv
module iccp_div #(
	parameter int unsigned CW = 16,
	parameter int unsigned FW = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [CW-1:0] count,
	input  logic [CW-1:0] limit,
	output logic [FW-1:0] q
);

	localparam int unsigned N = CW + FW;

	// restoring division of count << FW, one quotient bit per stage;
	// q keeps only the last FW quotient bits, i.e. the fraction
	logic [CW-1:0] rem_s [N];
	logic [CW-1:0] cnt_s [N];
	logic [FW-1:0] q_s   [N];

	for (genvar j = 0; j < N; j++) begin : gen_step
		logic [CW-1:0] rem_i;
		logic [CW-1:0] cnt_i;
		logic [FW-1:0] q_i;
		logic [CW:0]   part;
		logic          ge;

		if (j == 0) begin : gen_head
			assign rem_i = '0;
			assign cnt_i = count;
			assign q_i   = '0;
		end else begin : gen_chain
			assign rem_i = rem_s[j-1];
			assign cnt_i = cnt_s[j-1];
			assign q_i   = q_s[j-1];
		end

		assign part = {rem_i, cnt_i[CW-1]};
		assign ge   = (part >= {1'b0, limit});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? CW'(part - {1'b0, limit}) : CW'(part);
				cnt_s[j] <= cnt_i << 1;
				q_s[j]   <= {q_i[FW-2:0], ge};
			end
		end
	end

	assign q = q_s[N-1];

endmodule

>>> src/iccp_mul.sv
module iccp_mul #(
	parameter int unsigned AW = 16,
	parameter int unsigned BW = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);

	localparam int unsigned AL = AW / 2;
	localparam int unsigned AH = AW - AL;
	localparam int unsigned BL = BW / 2;
	localparam int unsigned BH = BW - BL;
	localparam int unsigned PW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;
	logic [PW-1:0]    base_s2;
	logic [PW-1:0]    cross_s2;
	logic [PW-1:0]    p_s3;

	// four half-width partial products, then the cross terms, then one add
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1    <= a[AL-1:0] * b[BL-1:0];
			lh_s1    <= a[AL-1:0] * b[BW-1:BL];
			hl_s1    <= a[AW-1:AL] * b[BL-1:0];
			hh_s1    <= a[AW-1:AL] * b[BW-1:BL];
			base_s2  <= {hh_s1, ll_s1};
			cross_s2 <= (PW'(lh_s1) << BL) + (PW'(hl_s1) << AL);
			p_s3     <= base_s2 + cross_s2;
		end
	end

	assign p = p_s3;

endmodule

>>> src/iccp_root.sv
module iccp_root #(
	parameter int unsigned FW = 16
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [FW+iccp_pkg::FIELD_BITS-1:0]  target,
	output logic [iccp_pkg::CHANNEL_BITS-1:0]   root
);

	localparam int unsigned CB = iccp_pkg::CHANNEL_BITS;
	localparam int unsigned TW = FW + iccp_pkg::FIELD_BITS;

	// largest root with root^2 << FW not above target, one bit per stage
	logic [CB-1:0] root_s [CB];
	logic [TW-1:0] tgt_s  [CB];

	for (genvar k = 0; k < CB; k++) begin : gen_bit
		logic [CB-1:0]   root_i;
		logic [TW-1:0]   tgt_i;
		logic [CB-1:0]   cand;
		logic [2*CB-1:0] sq;

		if (k == 0) begin : gen_head
			assign root_i = '0;
			assign tgt_i  = target;
		end else begin : gen_chain
			assign root_i = root_s[k-1];
			assign tgt_i  = tgt_s[k-1];
		end

		assign cand = root_i | (CB'(1) << (CB - 1 - k));
		assign sq   = cand * cand;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= ({sq, {FW{1'b0}}} <= tgt_i) ? cand : root_i;
				tgt_s[k]  <= tgt_i;
			end
		end
	end

	assign root = root_s[CB-1];

endmodule

>>> src/iteration_count_color_palette.sv
// channel    dir   handshake                   payload
// count      in    count_valid / count_ready   iteration_count[15:0]
// color      out   color_valid / color_ready   red[7:0] green[7:0] blue[7:0]
// cfg        in    cfg_valid / cfg_ready       cfg_index[3:0] cfg_data[15:0]
//
// one pixel per clock unless a stalled output freezes the pipeline; the divider takes
// one quotient bit per stage
// reset clears the valid bits and loads limit 100 and shift 0; no clearing pass
// a color stalled at the output freezes the pipeline only when its last stage is full
// cfg_ready is always high; writes with an unknown index are dropped
module iteration_count_color_palette #(
	parameter int unsigned COUNT_BITS    = 16,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  count_valid,
	output logic                                  count_ready,
	input  logic [iccp_pkg::FIELD_BITS-1:0]       iteration_count,
	output logic                                  color_valid,
	input  logic                                  color_ready,
	output logic [iccp_pkg::CHANNEL_BITS-1:0]     red,
	output logic [iccp_pkg::CHANNEL_BITS-1:0]     green,
	output logic [iccp_pkg::CHANNEL_BITS-1:0]     blue,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [iccp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [iccp_pkg::FIELD_BITS-1:0]       cfg_data
);

	localparam int unsigned CW  = COUNT_BITS;
	localparam int unsigned FW  = FRACTION_BITS;
	localparam int unsigned XB  = iccp_pkg::FIELD_BITS;
	localparam int unsigned CB  = iccp_pkg::CHANNEL_BITS;
	localparam int unsigned KW  = FW + 13;
	localparam int unsigned TW  = FW + XB;
	localparam int unsigned RPW = 4 * FW + 13;
	localparam int unsigned GPW = 4 * FW + 14;
	localparam int unsigned LAT = CW + FW + 10;

	localparam logic [FW:0] FRAC_ONE = (FW + 1)'(1) << FW;

	logic [XB-1:0] limit_q;
	logic [XB-1:0] shift_q;

	logic                en;
	iccp_pkg::pipe_ctl_t ctl_in;
	iccp_pkg::pipe_ctl_t ctl_last;

	logic [CW-1:0] count_w;
	logic [CW-1:0] limit_w;
	logic [FW-1:0] shift_w;
	logic [FW-1:0] q_div;
	logic [FW-1:0] q_eff;
	logic [FW-1:0] t_next;

	logic [FW-1:0] t_s1;
	logic [FW:0]   u_s1;
	logic [FW-1:0] t_s2;
	logic [FW:0]   u_s2;
	logic [KW-1:0] kr_s2;
	logic [KW-1:0] kg_s2;
	logic [TW-1:0] tgt_s2;

	logic [2*FW:0]      ut_p;
	logic [2*FW-1:0]    tt_p;
	logic [2*FW+12:0]   rt_p;
	logic [2*FW+12:0]   gt_p;
	logic [RPW-1:0]     red_p;
	logic [GPW-1:0]     green_p;
	logic [CB-1:0]      blue_r;

	logic [CB-1:0] red_s3;
	logic [CB-1:0] green_s3;
	logic [CB-1:0] red_s4;
	logic [CB-1:0] green_s4;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= iccp_pkg::LIMIT_RESET;
			shift_q <= iccp_pkg::SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (iccp_pkg::cfg_index_t'(cfg_index))
				iccp_pkg::CFG_ITERATION_LIMIT: limit_q <= cfg_data;
				iccp_pkg::CFG_PALETTE_SHIFT:   shift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	if (FW >= XB) begin : gen_shift_up
		assign shift_w = FW'(shift_q) << (FW - XB);
	end else begin : gen_shift_down
		assign shift_w = FW'(shift_q >> (XB - FW));
	end

	// pipeline advance: last stage empty or output register free
	assign en          = !ctl_last.valid || !color_valid || color_ready;
	assign count_ready = en;

	assign count_w = CW'(iteration_count);
	assign limit_w = CW'(limit_q);

	assign ctl_in.valid = count_valid;
	assign ctl_in.black = (count_w == limit_w);

	iccp_delay #(.W($bits(iccp_pkg::pipe_ctl_t)), .N(LAT)) u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (ctl_in),
		.q      (ctl_last)
	);

	iccp_div #(.CW(CW), .FW(FW)) u_div (
		.clk   (clk),
		.en    (en),
		.count (count_w),
		.limit (limit_w),
		.q     (q_div)
	);

	// a zero limit gives a zero quotient
	assign q_eff  = (limit_w == '0) ? '0 : q_div;
	assign t_next = q_eff + shift_w;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t_next;
			u_s1   <= FRAC_ONE - {1'b0, t_next};
			t_s2   <= t_s1;
			u_s2   <= u_s1;
			kr_s2  <= KW'(u_s1) * KW'(iccp_pkg::RED_GAIN);
			kg_s2  <= KW'(u_s1) * KW'(iccp_pkg::GREEN_GAIN);
			tgt_s2 <= TW'(t_s1) * TW'(iccp_pkg::BLUE_SCALE);
		end
	end

	// first product layer: u*t, t*t, 2295*u*t, 3825*u*t
	iccp_mul #(.AW(FW + 1), .BW(FW)) u_mul_ut (
		.clk (clk), .en (en), .a (u_s2), .b (t_s2), .p (ut_p)
	);

	iccp_mul #(.AW(FW), .BW(FW)) u_mul_tt (
		.clk (clk), .en (en), .a (t_s2), .b (t_s2), .p (tt_p)
	);

	iccp_mul #(.AW(KW), .BW(FW)) u_mul_rt (
		.clk (clk), .en (en), .a (kr_s2), .b (t_s2), .p (rt_p)
	);

	iccp_mul #(.AW(KW), .BW(FW)) u_mul_gt (
		.clk (clk), .en (en), .a (kg_s2), .b (t_s2), .p (gt_p)
	);

	// second layer: 2295*u*t^3 and 3825*u^2*t^2, exact
	iccp_mul #(.AW(2 * FW + 13), .BW(2 * FW)) u_mul_red (
		.clk (clk), .en (en), .a (rt_p), .b (tt_p), .p (red_p)
	);

	iccp_mul #(.AW(2 * FW + 13), .BW(2 * FW + 1)) u_mul_green (
		.clk (clk), .en (en), .a (gt_p), .b (ut_p), .p (green_p)
	);

	iccp_root #(.FW(FW)) u_root (
		.clk    (clk),
		.en     (en),
		.target (tgt_s2),
		.root   (blue_r)
	);

	// drop the 4*FW fraction bits and clamp; one extra stage lines up with the root
	always_ff @(posedge clk) begin
		if (en) begin
			red_s3   <= (|(red_p >> (4 * FW + CB))) ? '1 : red_p[4 * FW +: CB];
			green_s3 <= (|(green_p >> (4 * FW + CB))) ? '1 : green_p[4 * FW +: CB];
			red_s4   <= red_s3;
			green_s4 <= green_s3;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_valid <= 1'b0;
		end else if (en && ctl_last.valid) begin
			color_valid <= 1'b1;
		end else if (color_ready) begin
			color_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_last.valid) begin
			red   <= ctl_last.black ? '0 : red_s4;
			green <= ctl_last.black ? '0 : green_s4;
			blue  <= ctl_last.black ? '0 : blue_r;
		end
	end

endmodule

>>> src/iccp_checker.sv
`include "assert_macros.svh"

module iccp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              count_ready,
	input logic                              color_valid,
	input logic                              color_ready,
	input logic [iccp_pkg::CHANNEL_BITS-1:0] red,
	input logic [iccp_pkg::CHANNEL_BITS-1:0] green,
	input logic [iccp_pkg::CHANNEL_BITS-1:0] blue
);

	logic                                  color_stalled;
	logic [3*iccp_pkg::CHANNEL_BITS-1:0]   color_rgb;
	logic                                  dark_lit;

	assign color_stalled = color_valid && !color_ready;
	assign color_rgb     = {red, green, blue};
	assign dark_lit      = (blue == '0) && ((red != '0) || (green != '0));

	// a stalled color transaction stays offered
	`ASSERT_CLK(a_color_hold, color_stalled |=> color_valid, "color dropped while stalled")

	// and keeps its payload
	`ASSERT_CLK(a_color_stable, color_stalled |=> $stable(color_rgb), "color changed while stalled")

	// with the output register empty the pipeline always moves
	`ASSERT_CLK(a_ready_when_empty, !color_valid |-> count_ready, "input blocked with empty output")

	// blue is zero only near t = 0, where red and green are zero too
	`ASSERT_NEVER(a_dark_blue, color_valid && dark_lit, "red or green lit with zero blue")

endmodule

bind iteration_count_color_palette iccp_checker u_iccp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.count_ready (count_ready),
	.color_valid (color_valid),
	.color_ready (color_ready),
	.red         (red),
	.green       (green),
	.blue        (blue)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int unsigned COUNT_BITS    = 16;
	localparam int unsigned FRACTION_BITS = 16;
	localparam int unsigned PIPE_LATENCY  = COUNT_BITS + FRACTION_BITS + 10;

	localparam logic [63:0] COUNT_MASK = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [63:0] FRAC_ONE   = 64'd1 << FRACTION_BITS;
	localparam logic [63:0] FRAC_MASK  = FRAC_ONE - 64'd1;

	// index with no register behind it, the block drops the write
	localparam logic [iccp_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 4'hF;

	typedef struct {
		logic [iccp_pkg::CHANNEL_BITS-1:0] red;
		logic [iccp_pkg::CHANNEL_BITS-1:0] green;
		logic [iccp_pkg::CHANNEL_BITS-1:0] blue;
	} color_t;

	class palette_scoreboard;
		logic [iccp_pkg::FIELD_BITS-1:0] limit;
		logic [iccp_pkg::FIELD_BITS-1:0] shift;
		color_t expected_colors[$];
		int errors;

		function new();
			limit = iccp_pkg::LIMIT_RESET;
			shift = iccp_pkg::SHIFT_RESET;
			errors = 0;
		endfunction

		function void write_register(logic [iccp_pkg::CFG_INDEX_BITS-1:0] idx,
				logic [iccp_pkg::FIELD_BITS-1:0] data);
			case (idx)
				iccp_pkg::CFG_ITERATION_LIMIT: limit = data;
				iccp_pkg::CFG_PALETTE_SHIFT:   shift = data;
				default: ;
			endcase
		endfunction

		// exact floor(gain * u^u_pow * t^(4-u_pow) / 2^(4F)), clamped to 255
		function logic [7:0] bernstein(logic [127:0] gain, logic [FRACTION_BITS:0] u,
				logic [FRACTION_BITS:0] t, int unsigned u_pow);
			logic [127:0] acc;
			acc = gain;
			for (int i = 0; i < 4; i++)
				acc = acc * ((i < u_pow) ? u : t);
			acc = acc >> (4 * FRACTION_BITS);
			return (acc > 128'd255) ? 8'hFF : acc[7:0];
		endfunction

		// largest b with b*b * 2^F <= 255^2 * t
		function logic [7:0] sqrt_level(logic [FRACTION_BITS:0] t);
			logic [63:0] target;
			logic [63:0] c;
			logic [7:0] b;
			target = 64'(iccp_pkg::BLUE_SCALE) * t;
			b = 8'd0;
			for (int k = 7; k >= 0; k--) begin
				c = {56'd0, b} | (64'd1 << k);
				if (((c * c) << FRACTION_BITS) <= target)
					b = c[7:0];
			end
			return b;
		endfunction

		function color_t color_of(logic [iccp_pkg::FIELD_BITS-1:0] count);
			logic [63:0] cnt;
			logic [63:0] lim;
			logic [63:0] quot;
			logic [63:0] rot;
			logic [FRACTION_BITS:0] t;
			logic [FRACTION_BITS:0] u;
			color_t col;
			cnt = count & COUNT_MASK;
			lim = limit & COUNT_MASK;
			if (cnt == lim) begin
				col.red = '0;
				col.green = '0;
				col.blue = '0;
				return col;
			end
			quot = (lim != 64'd0) ? (cnt << FRACTION_BITS) / lim : 64'd0;
			if (FRACTION_BITS >= 16)
				rot = 64'(shift) << (FRACTION_BITS - 16);
			else
				rot = 64'(shift) >> (16 - FRACTION_BITS);
			t = (FRACTION_BITS + 1)'((quot + rot) & FRAC_MASK);
			u = (FRACTION_BITS + 1)'(FRAC_ONE - 64'(t));
			col.red = bernstein(128'(iccp_pkg::RED_GAIN), u, t, 1);
			col.green = bernstein(128'(iccp_pkg::GREEN_GAIN), u, t, 2);
			col.blue = sqrt_level(t);
			return col;
		endfunction

		function void note_count(logic [iccp_pkg::FIELD_BITS-1:0] count);
			expected_colors.push_back(color_of(count));
		endfunction

		function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			color_t exp_col;
			if (expected_colors.size() == 0) begin
				$display("%0t: unexpected color transaction r=%0d g=%0d b=%0d", $time, r, g, b);
				errors++;
				return;
			end
			exp_col = expected_colors.pop_front();
			if (r !== exp_col.red) begin
				$display("%0t: red mismatch, expected %0d, got %0d", $time, exp_col.red, r);
				errors++;
			end
			if (g !== exp_col.green) begin
				$display("%0t: green mismatch, expected %0d, got %0d", $time, exp_col.green, g);
				errors++;
			end
			if (b !== exp_col.blue) begin
				$display("%0t: blue mismatch, expected %0d, got %0d", $time, exp_col.blue, b);
				errors++;
			end
		endfunction

		function int pending();
			return expected_colors.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic count_valid;
	logic count_ready;
	logic [iccp_pkg::FIELD_BITS-1:0] iteration_count;
	logic color_valid;
	logic color_ready;
	logic [iccp_pkg::CHANNEL_BITS-1:0] red;
	logic [iccp_pkg::CHANNEL_BITS-1:0] green;
	logic [iccp_pkg::CHANNEL_BITS-1:0] blue;
	logic cfg_valid;
	logic cfg_ready;
	logic [iccp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [iccp_pkg::FIELD_BITS-1:0] cfg_data;

	palette_scoreboard sb;
	bit burst_phase;
	logic [iccp_pkg::FIELD_BITS-1:0] picks[$];

	iteration_count_color_palette #(
		.COUNT_BITS(COUNT_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.count_valid(count_valid),
		.count_ready(count_ready),
		.iteration_count(iteration_count),
		.color_valid(color_valid),
		.color_ready(color_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("iteration_count_color_palette test failed");
		$finish;
	end

	// output side back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		color_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && !burst_phase && $urandom_range(0, 3) == 0)
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
			if (stall_left > 0) begin
				color_ready <= 1'b0;
				stall_left--;
			end else begin
				color_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && color_valid && color_ready)
			sb.check_color(red, green, blue);
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (burst_phase || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [iccp_pkg::FIELD_BITS-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd1;
		if (r == 1)
			return 16'hFFFF;
		if (r == 2)
			return 16'd0;
		if (r < 7)
			return 16'($urandom_range(2, 300));
		return 16'($urandom_range(301, 65534));
	endfunction

	function automatic logic [iccp_pkg::FIELD_BITS-1:0] pick_shift();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	// mostly counts around one wrap of the palette, some exact limit hits
	function automatic logic [iccp_pkg::FIELD_BITS-1:0] pick_count(
			logic [iccp_pkg::FIELD_BITS-1:0] lim);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return lim;
		if (r < 7 && lim <= 16'd32767)
			return 16'($urandom_range(0, 2 * lim + 1));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic send_count(input logic [iccp_pkg::FIELD_BITS-1:0] value);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			count_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		count_valid <= 1'b1;
		iteration_count <= value;
		do @(posedge clk); while (!count_ready);
		sb.note_count(value);
	endtask

	task automatic send_all(input logic [iccp_pkg::FIELD_BITS-1:0] counts[$]);
		foreach (counts[i])
			send_count(counts[i]);
		count_valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [iccp_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [iccp_pkg::FIELD_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
	endtask

	// wait for all colors, then let the pipeline run empty
	task automatic settle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic apply_palette(input logic [iccp_pkg::FIELD_BITS-1:0] lim,
			input logic [iccp_pkg::FIELD_BITS-1:0] rot);
		settle();
		write_reg(iccp_pkg::CFG_ITERATION_LIMIT, lim);
		write_reg(iccp_pkg::CFG_PALETTE_SHIFT, rot);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [iccp_pkg::FIELD_BITS-1:0] lim;
		sb = new();
		burst_phase = 1'b0;
		count_valid = 1'b0;
		iteration_count = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset palette: black at the limit, zero position, wrap above the limit
		picks = '{16'd0, 16'd100, 16'd99, 16'd1, 16'd50, 16'd101, 16'd200, 16'd250,
			16'hFFFF, 16'h8000};
		send_all(picks);

		// zero limit: only count zero is black, the rest sits at the shift
		apply_palette(16'd0, 16'd12345);
		picks = '{16'd0, 16'd1, 16'hFFFF};
		send_all(picks);

		apply_palette(16'd1, 16'd0);
		picks = '{16'd0, 16'd1, 16'd2, 16'hFFFF};
		send_all(picks);

		apply_palette(16'hFFFF, 16'hFFFF);
		picks = '{16'hFFFF, 16'd0, 16'hFFFE, 16'h8000};
		send_all(picks);

		settle();
		write_reg(CFG_UNUSED_INDEX, 16'd5);
		cfg_valid <= 1'b0;
		apply_palette(16'd3, 16'h8000);
		picks = '{16'd1, 16'd2, 16'd5};
		send_all(picks);

		for (int p = 0; p < 8; p++) begin
			lim = pick_limit();
			apply_palette(lim, pick_shift());
			burst_phase = (p % 3 == 1);
			for (int n = 0; n < 80; n++)
				send_count(pick_count(lim));
			count_valid <= 1'b0;
			burst_phase = 1'b0;
		end

		settle();
		if (sb.errors == 0)
			$display("iteration_count_color_palette test passed");
		else
			$display("iteration_count_color_palette test failed");
		$finish;
	end
endmodule

>>> sim.f
+incdir+src
src/iccp_pkg.sv
src/iccp_delay.sv
src/iccp_div.sv
src/iccp_mul.sv
src/iccp_root.sv
src/iteration_count_color_palette.sv
src/iccp_checker.sv
tb/tb.sv
